FILE: rtl/pmx_pkg.sv
package pmx_pkg;

  // rounding and width constants
  localparam int unsigned PartW = 16;
  localparam int unsigned ProdW = 2 * PartW;
  localparam int unsigned SumW  = ProdW + 2;
  localparam int unsigned FracW = 12;
  localparam int unsigned RndW  = SumW - FracW;

  localparam logic signed [SumW-1:0]  RndHalf = SumW'(2048);
  localparam logic signed [RndW-1:0]  SatMax  = RndW'(32767);
  localparam logic signed [RndW-1:0]  SatMin  = -RndW'(32768);
  localparam logic        [PartW-1:0] PartMax = 16'h7fff;
  localparam logic        [PartW-1:0] PartMin = 16'h8000;

  // packed complex value, real part in the upper half
  typedef struct packed {
    logic signed [PartW-1:0] re;
    logic signed [PartW-1:0] im;
  } cplx_t;

  // input beat
  typedef struct packed {
    logic [31:0] vis_11;
    logic [31:0] vis_12;
    logic [31:0] vis_21;
    logic [31:0] vis_22;
    logic [31:0] gain_r0c0;
    logic [31:0] gain_r0c1;
    logic [31:0] gain_r1c0;
    logic [31:0] gain_r1c1;
    logic        left_multiply;
    logic        channel_end;
  } in_t;

  // result beat
  typedef struct packed {
    logic [31:0] out_11;
    logic [31:0] out_12;
    logic [31:0] out_21;
    logic [31:0] out_22;
    logic        channel_end_out;
  } out_t;

  // load enables for the two datapath register stages
  typedef struct packed {
    logic load_prod;
    logic load_sum;
  } stage_en_t;

  // round half up after the fractional shift, then clamp to 16 bits
  function automatic logic [PartW-1:0] round_sat(input logic signed [SumW-1:0] s);
    logic signed [SumW-1:0] t;
    logic signed [RndW-1:0] r;
    t = s + RndHalf;
    r = t[SumW-1:FracW];
    if (r > SatMax) begin
      return PartMax;
    end else if (r < SatMin) begin
      return PartMin;
    end else begin
      return r[PartW-1:0];
    end
  endfunction

endpackage

FILE: rtl/pmx_cmac.sv
module pmx_cmac
  import pmx_pkg::*;
(
  input  logic        clk,
  input  stage_en_t   en,
  input  cplx_t       g1,
  input  cplx_t       v1,
  input  cplx_t       g2,
  input  cplx_t       v2,
  input  logic        conj,
  output logic [31:0] result
);

  logic signed [ProdW-1:0] p_rr1, p_ii1, p_ri1, p_ir1;
  logic signed [ProdW-1:0] p_rr2, p_ii2, p_ri2, p_ir2;
  logic                    conj_q;
  logic signed [SumW-1:0]  rr_sum, ii_sum, ri_sum, ir_sum;
  logic signed [SumW-1:0]  re_sum, im_sum;

  // product stage: one multiplier per partial product
  always_ff @(posedge clk) begin
    if (en.load_prod) begin
      p_rr1  <= g1.re * v1.re;
      p_ii1  <= g1.im * v1.im;
      p_ri1  <= g1.re * v1.im;
      p_ir1  <= g1.im * v1.re;
      p_rr2  <= g2.re * v2.re;
      p_ii2  <= g2.im * v2.im;
      p_ri2  <= g2.re * v2.im;
      p_ir2  <= g2.im * v2.re;
      conj_q <= conj;
    end
  end

  // pair sums, sign of the imaginary gain terms set by conjugation
  always_comb begin
    rr_sum = SumW'(p_rr1) + SumW'(p_rr2);
    ii_sum = SumW'(p_ii1) + SumW'(p_ii2);
    ri_sum = SumW'(p_ri1) + SumW'(p_ri2);
    ir_sum = SumW'(p_ir1) + SumW'(p_ir2);
    if (conj_q) begin
      re_sum = rr_sum + ii_sum;
      im_sum = ri_sum - ir_sum;
    end else begin
      re_sum = rr_sum - ii_sum;
      im_sum = ri_sum + ir_sum;
    end
  end

  // result stage: round and saturate both parts
  always_ff @(posedge clk) begin
    if (en.load_sum) begin
      result <= {round_sat(re_sum), round_sat(im_sum)};
    end
  end

endmodule

FILE: rtl/polarization_matrix_apply.sv
// Polarization matrix apply: per frequency channel, a 2x2 complex matrix
// product of a calibration matrix M and a visibility matrix V.
// left_multiply high gives M*V, low gives V*M^H. Each part of each result
// entry is the sum of four 16x16 products, rounded half up after a 12-bit
// shift and saturated to signed 16 bits. channel_end travels with the beat.
// Channels: item (input) and result (output), each with valid and stall;
// a beat moves on a clock edge with valid high and stall low.
// Throughput: one beat per cycle while result_stall is low. An accepted beat
// loads the input register, then the product register and then the result
// register; result_valid rises as the result register loads.
// The receiver stalling holds the result register; the stages behind it
// keep filling, and item_stall rises only once all three stages are full.
// Reset (synchronous, active high) empties the pipeline; no result is
// shown until a new item has gone through.
module polarization_matrix_apply
  import pmx_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic item_valid,
  output logic item_stall,
  input  in_t  item,
  output logic result_valid,
  input  logic result_stall,
  output out_t result
);

  localparam int unsigned Lanes = 4;

  logic      s0_valid, s1_valid, s2_valid;
  logic      s0_valid_next, s1_valid_next, s2_valid_next;
  logic      s0_ready, s1_ready, s2_ready;
  in_t       s0;
  logic      s1_end, s2_end;
  stage_en_t en;

  cplx_t       m00, m01, m10, m11, v11, v12, v21, v22;
  cplx_t       g1 [Lanes];
  cplx_t       v1 [Lanes];
  cplx_t       g2 [Lanes];
  cplx_t       v2 [Lanes];
  logic [31:0] lane_out [Lanes];

  // pipeline handshake
  always_comb begin
    s2_ready     = !s2_valid || !result_stall;
    s1_ready     = !s1_valid || s2_ready;
    s0_ready     = !s0_valid || s1_ready;
    en.load_prod = s0_valid && s1_ready;
    en.load_sum  = s1_valid && s2_ready;
    s0_valid_next = s0_ready ? item_valid : s0_valid;
    s1_valid_next = s1_ready ? s0_valid : s1_valid;
    s2_valid_next = s2_ready ? s1_valid : s2_valid;
  end

  assign item_stall   = !s0_ready;
  assign result_valid = s2_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s0_valid <= s0_valid_next;
      s1_valid <= s1_valid_next;
      s2_valid <= s2_valid_next;
    end
  end

  // input register and channel_end side path
  always_ff @(posedge clk) begin
    if (item_valid && s0_ready) begin
      s0 <= item;
    end
    if (en.load_prod) begin
      s1_end <= s0.channel_end;
    end
    if (en.load_sum) begin
      s2_end <= s1_end;
    end
  end

  // operand routing for the selected product order
  always_comb begin
    m00 = cplx_t'(s0.gain_r0c0);
    m01 = cplx_t'(s0.gain_r0c1);
    m10 = cplx_t'(s0.gain_r1c0);
    m11 = cplx_t'(s0.gain_r1c1);
    v11 = cplx_t'(s0.vis_11);
    v12 = cplx_t'(s0.vis_12);
    v21 = cplx_t'(s0.vis_21);
    v22 = cplx_t'(s0.vis_22);
    if (s0.left_multiply) begin
      g1[0] = m00; v1[0] = v11; g2[0] = m01; v2[0] = v21;
      g1[1] = m00; v1[1] = v12; g2[1] = m01; v2[1] = v22;
      g1[2] = m10; v1[2] = v11; g2[2] = m11; v2[2] = v21;
      g1[3] = m10; v1[3] = v12; g2[3] = m11; v2[3] = v22;
    end else begin
      g1[0] = m00; v1[0] = v11; g2[0] = m01; v2[0] = v12;
      g1[1] = m10; v1[1] = v11; g2[1] = m11; v2[1] = v12;
      g1[2] = m00; v1[2] = v21; g2[2] = m01; v2[2] = v22;
      g1[3] = m10; v1[3] = v21; g2[3] = m11; v2[3] = v22;
    end
  end

  // one complex multiply-accumulate lane per result entry
  for (genvar i = 0; i < Lanes; i++) begin : g_lane
    pmx_cmac u_cmac (
      .clk    (clk),
      .en     (en),
      .g1     (g1[i]),
      .v1     (v1[i]),
      .g2     (g2[i]),
      .v2     (v2[i]),
      .conj   (!s0.left_multiply),
      .result (lane_out[i])
    );
  end

  assign result.out_11          = lane_out[0];
  assign result.out_12          = lane_out[1];
  assign result.out_21          = lane_out[2];
  assign result.out_22          = lane_out[3];
  assign result.channel_end_out = s2_end;

endmodule

FILE: rtl/pmx_checker.sv
module pmx_checker
  import pmx_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic item_valid,
  input logic item_stall,
  input in_t  item,
  input logic result_valid,
  input logic result_stall,
  input out_t result
);

  // a stalled result beat stays offered
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result beat dropped while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  // input only backs up when the output is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid && result_stall)
    else $error("input stalled with output free");

  // an accepted beat reaches the output when the receiver does not stall meanwhile
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) ##1 !result_stall ##1 !result_stall |=> result_valid)
    else $error("result missing three cycles after accept");

endmodule

bind polarization_matrix_apply pmx_checker u_pmx_checker (.*);
